>>> src/dtt_pkg.sv
package dtt_pkg;

  localparam int DEFAULT_SLOTS     = 16;
  localparam int DEFAULT_TIME_BITS = 48;
  localparam int OPCODE_W          = 3;
  localparam int HANDLE_W          = 4;
  localparam int STATUS_W          = 2;
  localparam logic [31:0] WINDOW_RESET = 32'd3600000;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ADD     = 3'd0,
    OP_CANCEL  = 3'd1,
    OP_REFRESH = 3'd2,
    OP_RESET   = 3'd3,
    OP_QUERY   = 3'd4,
    OP_COLLECT = 3'd5
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_INACTIVE = 2'd1,
    ST_FULL     = 2'd2
  } st_e;

endpackage

>>> src/dtt_if.sv
interface dtt_req_if import dtt_pkg::*; #(
  parameter int TIME_BITS = DEFAULT_TIME_BITS
);
  logic                 valid;
  logic                 ready;
  logic [OPCODE_W-1:0]  opcode;
  logic [HANDLE_W-1:0]  handle_in;
  logic [TIME_BITS-1:0] period_ms;
  logic                 repeat_flag;
  logic                 restart_now;
  logic [TIME_BITS-1:0] now_ms;

  modport source (output valid, opcode, handle_in, period_ms, repeat_flag, restart_now, now_ms,
                  input ready);
  modport sink   (input valid, opcode, handle_in, period_ms, repeat_flag, restart_now, now_ms,
                  output ready);
endinterface

interface dtt_rsp_if import dtt_pkg::*; #(
  parameter int TIME_BITS = DEFAULT_TIME_BITS
);
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [HANDLE_W-1:0]  handle_out;
  logic                 fired;
  logic [TIME_BITS-1:0] wait_ms;
  logic                 front_notify;
  logic                 last;

  modport source (output valid, status, handle_out, fired, wait_ms, front_notify, last,
                  input ready);
  modport sink   (input valid, status, handle_out, fired, wait_ms, front_notify, last,
                  output ready);
endinterface

interface dtt_cfg_if import dtt_pkg::*; #(
  parameter int TIME_BITS = DEFAULT_TIME_BITS
);
  logic                 valid;
  logic                 ready;
  logic [TIME_BITS-1:0] rollover_window_ms;

  modport source (output valid, rollover_window_ms, input ready);
  modport sink   (input valid, rollover_window_ms, output ready);
endinterface

>>> src/deadline_timer_table.sv
// Channel   Dir  Handshake     Payload
// req_i     in   valid/ready   opcode, handle_in, period_ms, repeat_flag, restart_now, now_ms
// rsp_o     out  valid/ready   status, handle_out, fired, wait_ms, front_notify, last
// cfg_i     in   valid/ready   rollover_window_ms (ready is always high)
//
// Cancel, unused opcodes, a full add, an inactive refresh and an empty collect are answered from
// idle; a reset that changes nothing first passes an update state. Query, add, refresh and
// reset each run one sweep of the slot memory at one slot per cycle.
// Collect with nothing due runs a due sweep only; otherwise a due sweep, one sweep per fired
// timer and a re-arm sweep follow in that order.
// Reset clears all control state; period and deadline memories are not cleared.
// A new request is taken only in idle while the result register is free.
module deadline_timer_table import dtt_pkg::*; #(
  parameter int TIMER_SLOTS = DEFAULT_SLOTS,
  parameter int TIME_BITS   = DEFAULT_TIME_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dtt_req_if.sink   req_i,
  dtt_rsp_if.source rsp_o,
  dtt_cfg_if.sink   cfg_i
);

  localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CNT_W  = $clog2(TIMER_SLOTS + 1);
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(TIMER_SLOTS);
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  typedef enum logic [2:0] {
    S_IDLE, S_UPD, S_UPD2, S_SETTLE, S_SWEEP, S_SW_END
  } state_e;

  typedef enum logic [2:0] {
    K_FRONT, K_QUERY, K_DUE, K_PICK, K_REARM
  } sweep_e;

  typedef struct packed {
    st_e                  status;
    logic [HANDLE_W-1:0]  handle;
    logic                 fired;
    logic [TIME_BITS-1:0] wait_ms;
    logic                 notify;
    logic                 last;
  } rsp_t;

  function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                   input logic [TIME_BITS-1:0] b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_BITS] ? TIME_MAX : s[TIME_BITS-1:0];
  endfunction

  function automatic rsp_t mk_rsp(input st_e st, input logic [HANDLE_W-1:0] h,
                                  input logic f, input logic [TIME_BITS-1:0] w,
                                  input logic n, input logic l);
    rsp_t r;
    r.status = st;
    r.handle = h;
    r.fired  = f;
    r.wait_ms = w;
    r.notify = n;
    r.last   = l;
    return r;
  endfunction

  state_e state_q;
  sweep_e kind_q;

  logic [TIMER_SLOTS-1:0] active_q, repeat_q, due_q, orig_due_q;
  logic [TIME_BITS-1:0]   window_q, prev_time_q;
  logic                   notify_pending_q, roll_q;

  op_e                    op_q;
  logic [SLOT_W-1:0]      h_q;
  logic [TIME_BITS-1:0]   period_q, now_q, start_q;
  logic                   fnow_q;

  logic [CNT_W-1:0]       cnt_q;
  logic [SLOT_W-1:0]      idx_s_q, best_q;
  logic                   vld_s_q, found_q;
  logic [TIME_BITS-1:0]   best_dl_q;

  logic                   we_dl_q, we_pd_q;
  logic [SLOT_W-1:0]      wa_q;
  logic [TIME_BITS-1:0]   wd_dl_q, wd_pd_q;

  logic [TIME_BITS-1:0]   dl_mem [TIMER_SLOTS];
  logic [TIME_BITS-1:0]   pd_mem [TIMER_SLOTS];
  logic [TIME_BITS-1:0]   rd_dl_q, rd_pd_q;
  logic [SLOT_W-1:0]      rd_addr;

  rsp_t                   rsp_q;
  logic                   rsp_valid_q;

  logic                   out_free, req_acc, h_valid, table_full, cand;
  logic [SLOT_W-1:0]      h_slot, free_idx;
  logic [TIMER_SLOTS-1:0] due_rem;
  logic [TIME_BITS-1:0]   query_wait;

  assign out_free = !rsp_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == S_IDLE) && out_free;
  assign req_acc = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;

  assign h_slot  = SLOT_W'(req_i.handle_in);
  assign h_valid = 32'(req_i.handle_in) < 32'(TIMER_SLOTS);
  assign table_full = &active_q;

  always_comb begin
    free_idx = '0;
    for (int j = TIMER_SLOTS - 1; j >= 0; j--) begin
      if (!active_q[j]) free_idx = SLOT_W'(j);
    end
  end

  always_comb begin
    due_rem = due_q;
    due_rem[best_q] = 1'b0;
  end

  assign cand = (kind_q == K_PICK) ? due_q[idx_s_q] : active_q[idx_s_q];

  always_comb begin
    if (!found_q) query_wait = TIME_MAX;
    else if (now_q >= best_dl_q) query_wait = '0;
    else query_wait = best_dl_q - now_q;
  end

  // In idle the slot named by the request is read so that its data is ready next cycle.
  always_comb begin
    if (state_q == S_IDLE) rd_addr = h_slot;
    else if (cnt_q < CNT_END) rd_addr = cnt_q[SLOT_W-1:0];
    else rd_addr = '0;
  end

  always_ff @(posedge clk_i) begin
    if (we_dl_q) dl_mem[wa_q] <= wd_dl_q;
    if (we_pd_q) pd_mem[wa_q] <= wd_pd_q;
    rd_dl_q <= dl_mem[rd_addr];
    rd_pd_q <= pd_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_IDLE;
      kind_q           <= K_FRONT;
      active_q         <= '0;
      repeat_q         <= '0;
      due_q            <= '0;
      orig_due_q       <= '0;
      window_q         <= TIME_BITS'(WINDOW_RESET);
      prev_time_q      <= '0;
      notify_pending_q <= 1'b0;
      roll_q           <= 1'b0;
      cnt_q            <= '0;
      vld_s_q          <= 1'b0;
      found_q          <= 1'b0;
      we_dl_q          <= 1'b0;
      we_pd_q          <= 1'b0;
      rsp_valid_q      <= 1'b0;
    end else begin
      we_dl_q <= 1'b0;
      we_pd_q <= 1'b0;
      if (rsp_o.ready) rsp_valid_q <= 1'b0;
      if (cfg_i.valid) window_q <= cfg_i.rollover_window_ms;

      unique case (state_q)
        S_IDLE: begin
          if (req_acc) begin
            op_q     <= op_e'(req_i.opcode);
            h_q      <= h_slot;
            period_q <= req_i.period_ms;
            now_q    <= req_i.now_ms;
            fnow_q   <= req_i.restart_now;
            case (op_e'(req_i.opcode))
              OP_ADD: begin
                if (table_full) begin
                  rsp_q       <= mk_rsp(ST_FULL, '0, 1'b0, '0, 1'b0, 1'b1);
                  rsp_valid_q <= 1'b1;
                end else begin
                  active_q[free_idx] <= 1'b1;
                  repeat_q[free_idx] <= req_i.repeat_flag;
                  h_q     <= free_idx;
                  wa_q    <= free_idx;
                  we_dl_q <= 1'b1;
                  we_pd_q <= 1'b1;
                  wd_pd_q <= req_i.period_ms;
                  wd_dl_q <= sat_add(req_i.now_ms, req_i.period_ms);
                  kind_q  <= K_FRONT;
                  state_q <= S_SETTLE;
                end
              end
              OP_CANCEL: begin
                if (h_valid && active_q[h_slot]) begin
                  active_q[h_slot] <= 1'b0;
                  rsp_q <= mk_rsp(ST_OK, '0, 1'b0, '0, 1'b0, 1'b1);
                end else begin
                  rsp_q <= mk_rsp(ST_INACTIVE, '0, 1'b0, '0, 1'b0, 1'b1);
                end
                rsp_valid_q <= 1'b1;
              end
              OP_REFRESH: begin
                if (h_valid && active_q[h_slot]) begin
                  state_q <= S_UPD;
                end else begin
                  rsp_q       <= mk_rsp(ST_INACTIVE, '0, 1'b0, '0, 1'b0, 1'b1);
                  rsp_valid_q <= 1'b1;
                end
              end
              OP_RESET: begin
                if (h_valid) begin
                  state_q <= S_UPD;
                end else begin
                  rsp_q       <= mk_rsp(ST_INACTIVE, '0, 1'b0, '0, 1'b0, 1'b1);
                  rsp_valid_q <= 1'b1;
                end
              end
              OP_QUERY: begin
                notify_pending_q <= 1'b0;
                kind_q  <= K_QUERY;
                cnt_q   <= '0;
                found_q <= 1'b0;
                state_q <= S_SWEEP;
              end
              OP_COLLECT: begin
                if (active_q == '0) begin
                  rsp_q       <= mk_rsp(ST_OK, '0, 1'b0, '0, 1'b0, 1'b1);
                  rsp_valid_q <= 1'b1;
                end else begin
                  roll_q      <= (prev_time_q > window_q) &&
                                 (req_i.now_ms < prev_time_q - window_q);
                  prev_time_q <= req_i.now_ms;
                  kind_q  <= K_DUE;
                  cnt_q   <= '0;
                  state_q <= S_SWEEP;
                end
              end
              default: begin
                rsp_q       <= mk_rsp(ST_OK, '0, 1'b0, '0, 1'b0, 1'b1);
                rsp_valid_q <= 1'b1;
              end
            endcase
          end
        end

        S_UPD: begin
          wa_q <= h_q;
          if (op_q == OP_REFRESH) begin
            we_dl_q <= 1'b1;
            wd_dl_q <= sat_add(now_q, rd_pd_q);
            kind_q  <= K_FRONT;
            state_q <= S_SETTLE;
          end else if (!fnow_q && period_q == rd_pd_q) begin
            rsp_q       <= mk_rsp(ST_OK, '0, 1'b0, '0, 1'b0, 1'b1);
            rsp_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end else if (!active_q[h_q]) begin
            rsp_q       <= mk_rsp(ST_INACTIVE, '0, 1'b0, '0, 1'b0, 1'b1);
            rsp_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end else begin
            if (fnow_q) start_q <= now_q;
            else if (rd_dl_q >= rd_pd_q) start_q <= rd_dl_q - rd_pd_q;
            else start_q <= '0;
            state_q <= S_UPD2;
          end
        end

        S_UPD2: begin
          we_dl_q <= 1'b1;
          we_pd_q <= 1'b1;
          wd_pd_q <= period_q;
          wd_dl_q <= sat_add(start_q, period_q);
          kind_q  <= K_FRONT;
          state_q <= S_SETTLE;
        end

        // Lets the last memory write land before the next read.
        S_SETTLE: begin
          cnt_q   <= '0;
          found_q <= 1'b0;
          state_q <= (kind_q == K_REARM) ? S_IDLE : S_SWEEP;
        end

        S_SWEEP: begin
          if (cnt_q < CNT_END) begin
            idx_s_q <= cnt_q[SLOT_W-1:0];
            vld_s_q <= 1'b1;
            cnt_q   <= cnt_q + 1'b1;
          end else begin
            vld_s_q <= 1'b0;
          end
          if (vld_s_q) begin
            case (kind_q)
              K_DUE: due_q[idx_s_q] <= active_q[idx_s_q] && (roll_q || rd_dl_q <= now_q);
              K_REARM: begin
                if (orig_due_q[idx_s_q]) begin
                  if (repeat_q[idx_s_q]) begin
                    we_dl_q <= 1'b1;
                    wa_q    <= idx_s_q;
                    wd_dl_q <= sat_add(now_q, rd_pd_q);
                  end else begin
                    active_q[idx_s_q] <= 1'b0;
                  end
                end
              end
              default: begin
                // Ascending scan with a strict compare keeps the lower slot on a tie.
                if (cand && (!found_q || rd_dl_q < best_dl_q)) begin
                  found_q   <= 1'b1;
                  best_q    <= idx_s_q;
                  best_dl_q <= rd_dl_q;
                end
              end
            endcase
          end
          if (cnt_q == CNT_END && !vld_s_q) state_q <= S_SW_END;
        end

        S_SW_END: begin
          case (kind_q)
            K_DUE: begin
              if (due_q == '0) begin
                if (out_free) begin
                  rsp_q       <= mk_rsp(ST_OK, '0, 1'b0, '0, 1'b0, 1'b1);
                  rsp_valid_q <= 1'b1;
                  state_q     <= S_IDLE;
                end
              end else begin
                orig_due_q <= due_q;
                kind_q  <= K_PICK;
                cnt_q   <= '0;
                found_q <= 1'b0;
                state_q <= S_SWEEP;
              end
            end
            K_REARM: state_q <= S_SETTLE;
            default: begin
              if (out_free) begin
                rsp_valid_q <= 1'b1;
                if (kind_q == K_PICK) begin
                  rsp_q   <= mk_rsp(ST_OK, HANDLE_W'(best_q), 1'b1, '0, 1'b0, due_rem == '0);
                  due_q   <= due_rem;
                  kind_q  <= (due_rem == '0) ? K_REARM : K_PICK;
                  cnt_q   <= '0;
                  found_q <= 1'b0;
                  state_q <= S_SWEEP;
                end else if (kind_q == K_QUERY) begin
                  rsp_q   <= mk_rsp(ST_OK, '0, 1'b0, query_wait, 1'b0, 1'b1);
                  state_q <= S_IDLE;
                end else begin
                  // An add reports the slot it took.
                  rsp_q <= mk_rsp(ST_OK, (op_q == OP_ADD) ? HANDLE_W'(h_q) : '0, 1'b0, '0,
                                  found_q && best_q == h_q && !notify_pending_q, 1'b1);
                  if (found_q && best_q == h_q) notify_pending_q <= 1'b1;
                  state_q <= S_IDLE;
                end
              end
            end
          endcase
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.status       = rsp_q.status;
  assign rsp_o.handle_out   = rsp_q.handle;
  assign rsp_o.fired        = rsp_q.fired;
  assign rsp_o.wait_ms      = rsp_q.wait_ms;
  assign rsp_o.front_notify = rsp_q.notify;
  assign rsp_o.last         = rsp_q.last;

`ifndef NO_ASSERTIONS
  a_notify_reported: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(notify_pending_q) |-> rsp_valid_q && rsp_q.notify)
    else $error("notify flag set without a notify result");

  a_due_subset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWEEP && kind_q == K_PICK) |-> (due_q & ~active_q) == '0)
    else $error("due timer is not active");

  a_pick_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SW_END && kind_q == K_PICK) |-> found_q)
    else $error("pick sweep found no due timer");

  a_busy_no_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWEEP) |-> !req_acc)
    else $error("request taken during a sweep");
`endif

endmodule

>>> verif/dtt_tb_if.sv
`timescale 1ns / 100ps
// The block's channel interfaces live with the RTL; this file holds the
// testbench's shared timing constants only.
package dtt_tb_pkg;
  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 7;
  localparam int STALL_LIMIT    = 20000;
endpackage

>>> verif/deadline_timer_table_tb.sv
`timescale 1ns / 100ps
module deadline_timer_table_tb;
  import dtt_pkg::*;
  import dtt_tb_pkg::*;

  localparam int SLOTS = 16;
  localparam int TW = 48;
  localparam logic [TW-1:0] TMAX = '1;

  typedef struct packed {
    logic [1:0]    status;
    logic [3:0]    handle;
    logic          fired;
    logic [TW-1:0] wait_ms;
    logic          notify;
    logic          last;
  } timer_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  dtt_req_if #(.TIME_BITS(TW)) req_if ();
  dtt_rsp_if #(.TIME_BITS(TW)) rsp_if ();
  dtt_cfg_if #(.TIME_BITS(TW)) cfg_if ();

  deadline_timer_table #(.TIMER_SLOTS(SLOTS), .TIME_BITS(TW)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source),
    .cfg_i (cfg_if.sink)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Shadow copy of the timer table.
  logic          tbl_active [SLOTS];
  logic          tbl_repeat [SLOTS];
  logic [TW-1:0] tbl_period [SLOTS];
  logic [TW-1:0] tbl_deadline [SLOTS];
  logic          tbl_written [SLOTS];
  logic [TW-1:0] last_collect_time;
  logic          notify_pending;
  logic [TW-1:0] window_ms;

  timer_rsp_t expected_rsps[$];
  int errors = 0;
  int rsp_count = 0;
  int fired_count = 0;
  int req_count = 0;
  int idle_cycles = 0;
  logic long_stall = 1'b0;
  logic [TW-1:0] now_clock;

  function automatic logic [TW-1:0] sat_sum(logic [TW-1:0] a, logic [TW-1:0] b);
    logic [TW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TW] ? TMAX : s[TW-1:0];
  endfunction

  function automatic logic ahead_of(int a, int b);
    if (tbl_deadline[a] != tbl_deadline[b]) return tbl_deadline[a] < tbl_deadline[b];
    return a < b;
  endfunction

  function automatic logic raise_notify(int h);
    for (int j = 0; j < SLOTS; j++)
      if (j != h && tbl_active[j] && ahead_of(j, h)) return 1'b0;
    if (notify_pending) return 1'b0;
    notify_pending = 1'b1;
    return 1'b1;
  endfunction

  function automatic int first_slot();
    int best;
    best = -1;
    for (int j = 0; j < SLOTS; j++)
      if (tbl_active[j] && (best < 0 || ahead_of(j, best))) best = j;
    return best;
  endfunction

  function automatic void push_one(logic [1:0] st, logic [3:0] h, logic [TW-1:0] w,
                                   logic n);
    timer_rsp_t r;
    r.status = st; r.handle = h; r.fired = 1'b0; r.wait_ms = w; r.notify = n;
    r.last = 1'b1;
    expected_rsps.insert(expected_rsps.size(), r);
  endfunction

  // Works out the results of one request and advances the shadow table.
  function automatic void predict_timer_op(logic [2:0] op, logic [3:0] h,
      logic [TW-1:0] per, logic rep, logic fnow, logic [TW-1:0] now);
    int j, e, b, k;
    logic roll;
    logic due [SLOTS];
    logic [TW-1:0] start;
    timer_rsp_t r;
    case (op)
      OP_ADD: begin
        j = 0;
        while (j < SLOTS && tbl_active[j]) j++;
        if (j == SLOTS) push_one(ST_FULL, 0, 0, 0);
        else begin
          tbl_active[j] = 1; tbl_repeat[j] = rep; tbl_period[j] = per;
          tbl_written[j] = 1; tbl_deadline[j] = sat_sum(now, per);
          push_one(ST_OK, j[3:0], 0, raise_notify(j));
        end
      end
      OP_CANCEL: begin
        if (!tbl_active[h]) push_one(ST_INACTIVE, 0, 0, 0);
        else begin
          tbl_active[h] = 0;
          push_one(ST_OK, 0, 0, 0);
        end
      end
      OP_REFRESH: begin
        if (!tbl_active[h]) push_one(ST_INACTIVE, 0, 0, 0);
        else begin
          tbl_deadline[h] = sat_sum(now, tbl_period[h]);
          push_one(ST_OK, 0, 0, raise_notify(h));
        end
      end
      OP_RESET: begin
        if (!fnow && per == tbl_period[h]) push_one(ST_OK, 0, 0, 0);
        else if (!tbl_active[h]) push_one(ST_INACTIVE, 0, 0, 0);
        else begin
          if (fnow) start = now;
          else if (tbl_deadline[h] >= tbl_period[h]) start = tbl_deadline[h] - tbl_period[h];
          else start = 0;
          tbl_period[h] = per;
          tbl_deadline[h] = sat_sum(start, per);
          push_one(ST_OK, 0, 0, raise_notify(h));
        end
      end
      OP_QUERY: begin
        e = first_slot();
        notify_pending = 0;
        if (e < 0) push_one(ST_OK, 0, TMAX, 0);
        else if (now >= tbl_deadline[e]) push_one(ST_OK, 0, 0, 0);
        else push_one(ST_OK, 0, tbl_deadline[e] - now, 0);
      end
      OP_COLLECT: begin
        if (first_slot() < 0) push_one(ST_OK, 0, 0, 0);
        else begin
          roll = last_collect_time > window_ms && now < last_collect_time - window_ms;
          last_collect_time = now;
          for (j = 0; j < SLOTS; j++)
            due[j] = tbl_active[j] && (roll || tbl_deadline[j] <= now);
          k = 0;
          forever begin
            b = -1;
            for (j = 0; j < SLOTS; j++)
              if (due[j] && (b < 0 || ahead_of(j, b))) b = j;
            if (b < 0) break;
            due[b] = 0;
            r.status = ST_OK; r.handle = b[3:0]; r.fired = 1; r.wait_ms = 0;
            r.notify = 0; r.last = 0;
            expected_rsps.insert(expected_rsps.size(), r);
            k++;
          end
          for (j = 0; j < SLOTS; j++)
            if (tbl_active[j] && (roll || tbl_deadline[j] <= now)) begin
              if (tbl_repeat[j]) tbl_deadline[j] = sat_sum(now, tbl_period[j]);
              else tbl_active[j] = 0;
            end
          if (k == 0) push_one(ST_OK, 0, 0, 0);
          else expected_rsps[$].last = 1;
        end
      end
      default: push_one(ST_OK, 0, 0, 0);
    endcase
  endfunction

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 0;

  task automatic send_timer_op(logic [2:0] op, logic [3:0] h, logic [TW-1:0] per,
                               logic rep, logic fnow, logic [TW-1:0] now);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    req_if.valid <= 1'b1;
    req_if.opcode <= op;
    req_if.handle_in <= h;
    req_if.period_ms <= per;
    req_if.repeat_flag <= rep;
    req_if.restart_now <= fnow;
    req_if.now_ms <= now;
    do @(posedge clk_i); while (!req_if.ready);
    predict_timer_op(op, h, per, rep, fnow, now);
    req_count++;
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    burst_left = 0;
    while (expected_rsps.size() != 0) @(posedge clk_i);
    repeat (SLOTS + 8) @(posedge clk_i);
  endtask

  task automatic write_window(logic [TW-1:0] value);
    drain_results();
    cfg_if.valid <= 1'b1;
    cfg_if.rollover_window_ms <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    window_ms = value;
  endtask

  // Handle of some active slot, or a random one if none is active or on one pick in eight.
  function automatic logic [3:0] pick_handle();
    int list[$];
    for (int j = 0; j < SLOTS; j++) if (tbl_active[j]) list.insert(list.size(), j);
    if (list.size() == 0 || $urandom_range(0, 7) == 0) return 4'($urandom_range(0, SLOTS-1));
    return 4'(list[$urandom_range(0, list.size()-1)]);
  endfunction

  function automatic logic [TW-1:0] rand_time();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [TW-1:0] rand_period();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return rand_time();
      2: return TMAX;
      default: return TW'($urandom_range(1, 2000));
    endcase
  endfunction

  task automatic test_directed_ops();
    send_timer_op(OP_QUERY, 0, 0, 0, 0, 0);
    send_timer_op(OP_COLLECT, 0, 0, 0, 0, 5);
    send_timer_op(OP_ADD, 0, 100, 1, 0, 10);
    send_timer_op(OP_ADD, 0, 50, 0, 0, 10);
    send_timer_op(OP_ADD, 0, TMAX, 1, 1, TMAX);
    send_timer_op(OP_QUERY, 0, 0, 0, 0, 20);
    send_timer_op(OP_ADD, 0, 0, 0, 0, 10);
    send_timer_op(OP_CANCEL, 4'd15, 0, 0, 0, 0);
    send_timer_op(OP_REFRESH, 4'd1, 0, 0, 0, 30);
    send_timer_op(OP_RESET, 4'd0, 100, 0, 0, 40);
    send_timer_op(OP_RESET, 4'd0, 7, 0, 0, 40);
    send_timer_op(OP_RESET, 4'd1, 300, 0, 1, 45);
    send_timer_op(OP_RESET, 4'd9, 5, 0, 1, 45);
    send_timer_op(3'd6, 4'd3, TMAX, 1, 1, TMAX);
    send_timer_op(3'd7, 0, 0, 0, 0, 0);
    send_timer_op(OP_COLLECT, 0, 0, 0, 0, 60);
    send_timer_op(OP_CANCEL, 4'd3, 0, 0, 0, 0);
    send_timer_op(OP_COLLECT, 0, 0, 0, 0, 10000);
  endtask

  task automatic test_full_table();
    for (int i = 0; i < SLOTS + 2; i++)
      send_timer_op(OP_ADD, 0, TW'($urandom_range(0, 500)), 1'($urandom), 0, now_clock);
    send_timer_op(OP_QUERY, 0, 0, 0, 0, now_clock);
  endtask

  // A backward jump beyond the window expires every active timer.
  task automatic test_rollover(logic [TW-1:0] win);
    write_window(win);
    now_clock = TW'(5000000);
    send_timer_op(OP_ADD, 0, TMAX, 1, 0, now_clock);
    send_timer_op(OP_COLLECT, 0, 0, 0, 0, now_clock);
    send_timer_op(OP_COLLECT, 0, 0, 0, 0, TW'(1));
    now_clock = 1;
  endtask

  task automatic test_random_ops(int count);
    logic [2:0] op;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 7) now_clock = sat_sum(now_clock, TW'($urandom_range(0, 400)));
      else if ($urandom_range(0, 3) == 0) now_clock = rand_time();
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4: op = OP_ADD;
        5, 6: op = OP_CANCEL;
        7, 8: op = OP_REFRESH;
        9, 10, 11: op = OP_RESET;
        12, 13: op = OP_QUERY;
        19: op = 3'($urandom_range(6, 7));
        default: op = OP_COLLECT;
      endcase
      if (op == OP_RESET) begin : reset_pick
        logic [3:0] h;
        logic fn;
        h = pick_handle();
        fn = 1'($urandom);
        // Keeping the start of a never-written slot would read undefined state.
        if (!tbl_written[h]) fn = 1'b1;
        send_timer_op(op, h, $urandom_range(0, 3) == 0 ? tbl_period[h] : rand_period(), 0,
                      fn, now_clock);
      end else
        send_timer_op(op, pick_handle(), rand_period(), 1'($urandom), 1'($urandom),
                      now_clock);
    end
  endtask

  task automatic test_backpressure();
    long_stall <= 1'b1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        long_stall <= 1'b0;
      end
    join_none
    test_random_ops(20);
    drain_results();
  endtask

  // Receiver: stalls on a rotating pattern, with quiet stretches.
  logic [15:0] stall_pattern = 16'hffff;
  always @(posedge clk_i) begin
    if ($urandom_range(0, 63) == 0) begin
      case ($urandom_range(0, 2))
        0: stall_pattern <= 16'hffff;
        1: stall_pattern <= 16'($urandom);
        default: stall_pattern <= 16'h00ff;
      endcase
    end else
      stall_pattern <= {stall_pattern[14:0], stall_pattern[15]};
    rsp_if.ready <= rst_ni && !long_stall && stall_pattern[0];
  end

  always @(posedge clk_i) begin : check_results
    timer_rsp_t got, exp_r;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got.status = rsp_if.status; got.handle = rsp_if.handle_out; got.fired = rsp_if.fired;
      got.wait_ms = rsp_if.wait_ms; got.notify = rsp_if.front_notify; got.last = rsp_if.last;
      rsp_count++;
      if (got.fired) fired_count++;
      if (expected_rsps.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none, actual %p", $realtime, got);
      end else begin
        exp_r = expected_rsps.pop_front();
        if (got.status !== exp_r.status)
          $display("%0t status: expected %0d actual %0d", $realtime, exp_r.status, got.status);
        if (got.handle !== exp_r.handle)
          $display("%0t handle_out: expected %0d actual %0d", $realtime, exp_r.handle,
                   got.handle);
        if (got.fired !== exp_r.fired)
          $display("%0t fired: expected %0b actual %0b", $realtime, exp_r.fired, got.fired);
        if (got.wait_ms !== exp_r.wait_ms)
          $display("%0t wait_ms: expected %0d actual %0d", $realtime, exp_r.wait_ms,
                   got.wait_ms);
        if (got.notify !== exp_r.notify)
          $display("%0t front_notify: expected %0b actual %0b", $realtime, exp_r.notify,
                   got.notify);
        if (got.last !== exp_r.last)
          $display("%0t last: expected %0b actual %0b", $realtime, exp_r.last, got.last);
        if (got !== exp_r) errors++;
      end
    end
  end

  // Watchdog on cycles in which none of the three channels moves anything.
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    req_if.valid = 0; req_if.opcode = '0; req_if.handle_in = 0; req_if.period_ms = 0;
    req_if.repeat_flag = 0; req_if.restart_now = 0; req_if.now_ms = 0;
    cfg_if.valid = 0; cfg_if.rollover_window_ms = 0;
    for (int j = 0; j < SLOTS; j++) begin
      tbl_active[j] = 0; tbl_repeat[j] = 0; tbl_period[j] = 0; tbl_deadline[j] = 0;
      tbl_written[j] = 0;
    end
    last_collect_time = 0;
    notify_pending = 0;
    window_ms = TW'(WINDOW_RESET);
    now_clock = 100;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_ops();
    test_full_table();
    test_rollover(0);
    test_random_ops(100);
    test_backpressure();
    test_rollover(TMAX);
    test_random_ops(60);
    test_rollover(TW'(WINDOW_RESET));
    test_random_ops(100);

    drain_results();
    $display("Sent %0d requests, checked %0d results, %0d of them fired timers.",
             req_count, rsp_count, fired_count);
    $display("Window settings 0, reset value and maximum; table full and rollover included.");
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

>>> sim.f
src/dtt_pkg.sv
src/dtt_if.sv
src/deadline_timer_table.sv
verif/dtt_tb_if.sv
verif/deadline_timer_table_tb.sv
